FILE: design/ulebd_pkg.sv
// Shared types and constants for the strict ULEB128 decoder.
package ulebd_pkg;

    localparam int unsigned MAX_BYTES = 10;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_NONCANON = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_TOOLONG  = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  seen;
    } t_state;

    typedef struct packed {
        logic        vld;
        logic [63:0] value;
        logic [3:0]  count;
        logic [2:0]  status;
    } t_result;

endpackage

FILE: design/uleb128_strict_decoder.sv
// Top level of the strict ULEB128 decoder: input register, decode step, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one stream byte per transfer,
//   or an end marker (i_input_end) that closes a partial value as truncated.
//   Output channel (o_out_valid / i_out_ready) carries one result per finished
//   value: decoded value, bytes consumed and status.
//   A byte in the input register is decoded when that register advances, and any
//   result it gives is loaded into the result register and shown from there.
//   Throughput: one byte per cycle while the receiver does not stall, set by the
//   single accumulator update that each byte needs before the next byte is decoded.
//   When the receiver stalls, the result register holds, the input register
//   takes at most one byte more, then o_in_ready drops.
//   Reset (i_rst_n low, synchronous) empties both registers, clears the
//   accumulator and byte count and sets max_value to all ones.
//   i_cfg_we writes max_value from i_cfg_data; write it only while idle.
module uleb128_strict_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_input_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_decoded_value,
    output logic [3:0]  o_byte_count,
    output logic [2:0]  o_status
);

    logic [63:0]         r_max_value;
    logic                r_in_vld;
    logic [7:0]          r_in_byte;
    logic                r_in_end;
    ulebd_pkg::t_state   r_state;
    ulebd_pkg::t_state   n_state;
    ulebd_pkg::t_result  step_res;
    logic                r_out_vld;
    logic [63:0]         r_out_value;
    logic [3:0]          r_out_count;
    logic [2:0]          r_out_status;
    logic                advance;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    ulebd_step u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .i_end       (r_in_end),
        .i_max_value (r_max_value),
        .o_state     (n_state),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= '1;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_value <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_vld <= step_res.vld;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_input_end;
        end
        if (advance && step_res.vld) begin
            r_out_value  <= step_res.value;
            r_out_count  <= step_res.count;
            r_out_status <= step_res.status;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_decoded_value = r_out_value;
    assign o_byte_count    = r_out_count;
    assign o_status        = r_out_status;

endmodule

FILE: design/ulebd_step.sv
// Per-byte decode step: next accumulator state and optional result.
module ulebd_step (
    input  ulebd_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_end,
    input  logic [63:0]        i_max_value,
    output ulebd_pkg::t_state  o_state,
    output ulebd_pkg::t_result o_res
);

    logic [3:0]  pos;
    logic [3:0]  cnt;
    logic [5:0]  shamt;
    logic [6:0]  payload;
    logic [63:0] acc_new;
    logic        last_pos;

    assign pos      = i_state.seen;
    assign cnt      = pos + 4'd1;
    assign shamt    = {2'b00, pos} * 6'd7;
    assign payload  = i_byte[6:0];
    assign acc_new  = i_state.acc | ({57'd0, payload} << shamt);
    assign last_pos = (cnt >= 4'(ulebd_pkg::MAX_BYTES));

    always_comb begin
        o_state      = i_state;
        o_res.vld    = 1'b0;
        o_res.value  = 64'd0;
        o_res.count  = cnt;
        o_res.status = ulebd_pkg::ST_OK;
        if (i_end) begin
            o_res.count  = pos;
            o_res.status = ulebd_pkg::ST_TRUNC;
            if (pos != 4'd0) begin
                o_res.vld = 1'b1;
                o_state   = '0;
            end
        end else if (shamt == 6'd63 && payload > 7'd1) begin
            o_res.vld    = 1'b1;
            o_res.status = ulebd_pkg::ST_OVERFLOW;
            o_state      = '0;
        end else if (!i_byte[7]) begin
            o_res.vld = 1'b1;
            o_state   = '0;
            if (pos != 4'd0 && payload == 7'd0) begin
                o_res.status = ulebd_pkg::ST_NONCANON;
            end else if (acc_new > i_max_value) begin
                o_res.status = ulebd_pkg::ST_RANGE;
            end else begin
                o_res.value = acc_new;
            end
        end else if (last_pos) begin
            o_res.vld    = 1'b1;
            o_res.count  = 4'(ulebd_pkg::MAX_BYTES);
            o_res.status = ulebd_pkg::ST_TOOLONG;
            o_state      = '0;
        end else begin
            o_state.acc  = acc_new;
            o_state.seen = cnt;
        end
    end

endmodule

FILE: design/ulebd_checker.sv
// Port-level assertions for the strict ULEB128 decoder, bound to the top level.
module ulebd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_decoded_value,
    input logic [3:0]  o_byte_count,
    input logic [2:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_decoded_value)
            && $stable(o_byte_count) && $stable(o_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ulebd_pkg::ST_TRUNC)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ulebd_pkg::ST_OK |-> o_decoded_value == 64'd0)
        else $error("value not zero on error status");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_count != 4'd0
            && o_byte_count <= 4'(ulebd_pkg::MAX_BYTES))
        else $error("byte count out of range");

    a_toolong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ulebd_pkg::ST_TOOLONG
            |-> o_byte_count == 4'(ulebd_pkg::MAX_BYTES))
        else $error("too-long result without full byte count");

endmodule

bind uleb128_strict_decoder ulebd_checker u_ulebd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_decoded_value (o_decoded_value),
    .o_byte_count    (o_byte_count),
    .o_status        (o_status)
);

FILE: tb/uleb128_strict_decoder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the strict ULEB128 decoder: directed table, then random streams.
module uleb128_strict_decoder_test;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  count;
        logic [2:0]  status;
    } t_dec_result;

    typedef struct packed {
        logic [3:0]  rep;
        logic [7:0]  b;
        logic        e;
        logic        typed;
        t_dec_result want;
    } t_stim_row;

    localparam logic [3:0] FULL_COUNT = 4'(ulebd_pkg::MAX_BYTES);
    localparam int ITEMS_PER_PHASE = 219;
    localparam int LAST_PHASE = 8;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_input_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_decoded_value;
    logic [3:0]  o_byte_count;
    logic [2:0]  o_status;

    // decoder shadow state
    logic [63:0] max_limit = '1;
    logic [63:0] acc_bits = '0;
    logic [3:0]  seen_bytes = '0;

    t_dec_result due_results[$];
    int err_count = 0;
    int items_sent = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    // end marker between values, short values, noncanonical, truncation, repeated end, overflow
    t_stim_row directed_rows [0:11] = '{
        '{4'd1, 8'ha5, 1'b1, 1'b0, '0},
        '{4'd1, 8'h00, 1'b0, 1'b1, '{64'd0, 4'd1, ulebd_pkg::ST_OK}},
        '{4'd1, 8'h7f, 1'b0, 1'b1, '{64'd127, 4'd1, ulebd_pkg::ST_OK}},
        '{4'd1, 8'h80, 1'b0, 1'b0, '0},
        '{4'd1, 8'h00, 1'b0, 1'b1, '{64'd0, 4'd2, ulebd_pkg::ST_NONCANON}},
        '{4'd1, 8'hff, 1'b0, 1'b0, '0},
        '{4'd1, 8'h01, 1'b0, 1'b0, '0},
        '{4'd1, 8'h85, 1'b0, 1'b0, '0},
        '{4'd1, 8'h00, 1'b1, 1'b1, '{64'd0, 4'd1, ulebd_pkg::ST_TRUNC}},
        '{4'd1, 8'hff, 1'b1, 1'b0, '0},
        '{4'd9, 8'hff, 1'b0, 1'b0, '0},
        '{4'd1, 8'h82, 1'b0, 1'b1, '{64'd0, 4'd10, ulebd_pkg::ST_OVERFLOW}}
    };

    uleb128_strict_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_input_end     (i_input_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_decoded_value (o_decoded_value),
        .o_byte_count    (o_byte_count),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("uleb128_strict_decoder_test NOT OK");
        $finish;
    end

    function automatic bit uleb_decode_byte(input logic [7:0] b, input logic e,
                                            output t_dec_result r);
        logic [3:0]  pos;
        int unsigned shift;
        logic [6:0]  payload;
        r = '0;
        if (e) begin
            if (seen_bytes == 0) return 1'b0;
            r.count = seen_bytes;
            r.status = ulebd_pkg::ST_TRUNC;
        end else begin
            pos = seen_bytes;
            shift = 7 * pos;
            payload = b[6:0];
            if (shift == 63 && payload > 1) begin
                r.count = pos + 4'd1;
                r.status = ulebd_pkg::ST_OVERFLOW;
            end else begin
                acc_bits |= {57'd0, payload} << shift;
                if (!b[7]) begin
                    r.count = pos + 4'd1;
                    if (pos != 0 && payload == 0) begin
                        r.status = ulebd_pkg::ST_NONCANON;
                    end else if (acc_bits > max_limit) begin
                        r.status = ulebd_pkg::ST_RANGE;
                    end else begin
                        r.status = ulebd_pkg::ST_OK;
                        r.value = acc_bits;
                    end
                end else if (pos + 4'd1 >= FULL_COUNT) begin
                    r.count = FULL_COUNT;
                    r.status = ulebd_pkg::ST_TOOLONG;
                end else begin
                    seen_bytes = pos + 4'd1;
                    return 1'b0;
                end
            end
        end
        acc_bits = '0;
        seen_bytes = '0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = max_limit;
            1: v = max_limit + 1;
            2: v = max_limit - 1;
            3: v = '1;
            4: v = '0;
            default: v = v >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    function automatic logic [63:0] phase_limit(input int p);
        case (p)
            2: return 64'd0;
            3: return 64'd127;
            4: return {$urandom, $urandom};
            5: return 64'h7fff_ffff_ffff_ffff;
            6: return 64'h8000_0000_0000_0000;
            7: return 64'($urandom_range(0, 1 << 20));
            default: return '1;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        t_dec_result want;
        if (due_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result value=%h count=%0d status=%0d",
                                    o_decoded_value, o_byte_count, o_status));
            return;
        end
        want = due_results.pop_front();
        if (o_decoded_value !== want.value)
            flag_mismatch($sformatf("value %h, want %h", o_decoded_value, want.value));
        if (o_byte_count !== want.count)
            flag_mismatch($sformatf("byte count %0d, want %0d", o_byte_count, want.count));
        if (o_status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
    endtask

    // one input transfer; typed result overrides the prediction
    task automatic push_byte(input logic [7:0] b, input logic e, input bit use_typed,
                             input t_dec_result typed);
        t_dec_result r;
        int gap;
        if (!(e && seen_bytes == 0)) items_sent++;
        if (uleb_decode_byte(b, e, r) || use_typed)
            due_results.push_back(use_typed ? typed : r);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_input_end <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_canonical(input logic [63:0] v, input bit pad);
        logic [63:0] rest;
        logic [7:0]  b;
        int n;
        rest = v;
        do begin
            b = {1'b0, rest[6:0]};
            rest = rest >> 7;
            if (rest != 0 || pad) b[7] = 1'b1;
            push_byte(b, 1'b0, 1'b0, '0);
        end while (rest != 0);
        if (pad) begin
            n = $urandom_range(0, 3);
            repeat (n) push_byte(8'h80, 1'b0, 1'b0, '0);
            push_byte(8'h00, 1'b0, 1'b0, '0);
        end
    endtask

    task automatic send_random_sequence();
        int kind;
        int n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            send_canonical(pick_value(), 1'b0);
        end else if (kind < 60) begin
            send_canonical(pick_value(), 1'b1);
        end else if (kind < 74) begin
            for (int k = 0; k < 9; k++) begin
                b = 8'($urandom_range(0, 255));
                push_byte(b | 8'h80, 1'b0, 1'b0, '0);
            end
            if (kind < 67) begin
                b = {7'b1000000, 1'($urandom_range(0, 1))};
            end else begin
                b = 8'($urandom_range(2, 127));
                b[7] = 1'($urandom_range(0, 1));
            end
            push_byte(b, 1'b0, 1'b0, '0);
        end else if (kind < 82) begin
            n = $urandom_range(1, 9);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                push_byte(b | 8'h80, 1'b0, 1'b0, '0);
            end
            b = 8'($urandom_range(0, 255));
            push_byte(b, 1'b1, 1'b0, '0);
        end else if (kind < 90) begin
            b = 8'($urandom_range(0, 255));
            push_byte(b, 1'b1, 1'b0, '0);
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                b = 8'($urandom_range(0, 255));
                push_byte(b, $urandom_range(0, 9) == 0, 1'b0, '0);
            end
        end
    endtask

    // close any partial value, drain, then write max_value while idle
    task automatic retune_limit(input logic [63:0] v);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        push_byte(b, 1'b1, 1'b0, '0);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (6) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        max_limit = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver: checks each transfer and throttles ready
    initial begin
        int gap_left;
        int hold_left;
        gap_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result();
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_out_ready <= 1'b0;
            end else begin
                gap_left = pick_gap();
                i_out_ready <= (gap_left == 0);
            end
        end
    end

    initial begin
        bit paused;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            for (int k = 0; k < directed_rows[i].rep; k++)
                push_byte(directed_rows[i].b, directed_rows[i].e,
                          directed_rows[i].typed && k == directed_rows[i].rep - 1,
                          directed_rows[i].want);

        paused = 1'b0;
        for (int p = 1; p <= LAST_PHASE; p++) begin
            retune_limit(phase_limit(p));
            calm = (p == 3 || p == 6);
            if (p == 4) hold_req = 1'b1;
            while (items_sent < 20 + p * ITEMS_PER_PHASE) begin
                send_random_sequence();
                if (p == 2 && !paused && items_sent >= 20 + 3 * ITEMS_PER_PHASE / 2) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        calm = 1'b0;

        push_byte(8'h00, 1'b1, 1'b0, '0);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("uleb128_strict_decoder_test OK");
        else
            $display("uleb128_strict_decoder_test NOT OK");
        $finish;
    end

endmodule
